/* rtl/ecp_pkg.sv */
// Shared types, constants and stage counts for the Eckert III projection pipeline.
// Used by every module under rtl; depends on nothing.
package ecp_pkg;

	localparam int CoordW = 40;
	localparam int DiffW = CoordW + 1;
	localparam int QuoW = 42;
	localparam int FracW = 28;
	localparam int CoefW = 30;
	localparam int RootW = CoefW - 1;
	localparam int SumW = 48;

	localparam int DivLat = QuoW + 1;
	localparam int CoefLat = RootW + 4;
	localparam int QIdx = 2 + DivLat;
	localparam int CoefIdx = QIdx + CoefLat;
	localparam int TotalLat = QIdx + 1 + CoefLat + DivLat + 4;

	localparam logic [30:0] CxQ = 31'd1813499261;
	localparam logic [31:0] CyQ = 32'd3626998523;
	localparam logic [30:0] CbQ = 31'd1740684681;
	localparam logic [31:0] AxisReset = 32'd1632803072;

	localparam logic [CoefW-1:0] One28 = 30'h1000_0000;
	localparam logic [CoefW-1:0] LatCap = 30'h2000_0000;

	localparam logic signed [SumW-1:0] Max40 = 48'sh007F_FFFF_FFFF;
	localparam logic signed [SumW-1:0] Min40 = 48'shFF80_0000_0000;

	typedef enum logic [1:0] {
		RegAxis = 2'd0,
		RegLon0 = 2'd1,
		RegFe   = 2'd2,
		RegFn   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic            ovf;
		logic [QuoW-1:0] q;
	} quo_t;

	typedef struct packed {
		logic             cmd;
		logic             n1;
		logic             n2;
		logic [DiffW-1:0] m1;
		logic [DiffW-1:0] m2;
	} front_t;

	typedef struct packed {
		logic            cmd;
		logic            n1;
		logic            n2;
		logic            ova;
		logic            ovb;
		logic [QuoW-1:0] a;
		logic [QuoW-1:0] b;
	} mid_t;

	typedef struct packed {
		mid_t             mid;
		logic [CoefW-1:0] c;
	} back_t;

endpackage

/* rtl/ecp_wdiv.sv */
// Pipelined restoring divider: (num * 2^60) / den, 42 quotient bits, one bit per stage.
// Flags quotients of 2^42 and above. Depends on ecp_pkg.
module ecp_wdiv
	import ecp_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [DiffW-1:0] num,
	input  logic [63:0]      den,
	output quo_t             res
);

	logic [63:0]     rem_s [0:QuoW];
	logic [QuoW-1:0] quo_s [0:QuoW];
	logic            ovf_s [0:QuoW];
	logic [63:0]     top;

	assign top = {5'd0, num, 18'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= top;
			quo_s[0] <= '0;
			ovf_s[0] <= (top >= den);
		end
	end

	for (genvar j = 0; j < QuoW; j++) begin : g_step
		logic [64:0] trial;
		logic        fits;

		assign trial = {rem_s[j], 1'b0};
		assign fits = (trial >= {1'b0, den});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fits ? 64'(trial - {1'b0, den}) : trial[63:0];
				quo_s[j+1] <= {quo_s[j][QuoW-2:0], fits};
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign res.ovf = ovf_s[QuoW];
	assign res.q = quo_s[QuoW];

endmodule

/* rtl/ecp_coef.sv */
// Scale term c = 1 + sqrt(max(0, 1 - CB*lat^2)) in Q.28, with a one-bit-per-stage root.
// Depends on ecp_pkg.
module ecp_coef
	import ecp_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [CoefW-1:0] lat,
	output logic [CoefW-1:0] coef
);

	localparam int RemW = 2 * RootW - 1;
	localparam int TrialW = 2 * RootW + 1;

	logic [59:0]      lsq;
	logic [61:0]      pprod;
	logic [30:0]      sq_s1;
	logic [29:0]      p_s2;
	logic [CoefW-1:0] sdiff;
	logic [RemW-1:0]  rem_s [0:RootW];
	logic [RootW-1:0] root_s [0:RootW];
	logic [CoefW-1:0] coef_s;

	assign lsq = {30'd0, lat} * {30'd0, lat};
	assign pprod = {31'd0, sq_s1} * {31'd0, CbQ};
	assign sdiff = (p_s2 >= One28) ? '0 : One28 - p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= lsq[58:28];
			p_s2 <= pprod[61:32];
			rem_s[0] <= {sdiff[RootW-1:0], 28'd0};
			root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < RootW; j++) begin : g_root
		localparam int B = RootW - 1 - j;
		logic [TrialW-1:0] trial;
		logic              fits;

		assign trial = ({{(RootW+1){1'b0}}, root_s[j]} << (B + 1))
			| ({{(TrialW-1){1'b0}}, 1'b1} << (2 * B));
		assign fits = ({2'd0, rem_s[j]} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fits ? RemW'({2'd0, rem_s[j]} - trial) : rem_s[j];
				root_s[j+1] <= fits ? (root_s[j] | ({{(RootW-1){1'b0}}, 1'b1} << B))
					: root_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s <= One28 + {1'b0, root_s[RootW]};
		end
	end

	assign coef = coef_s;

endmodule

/* rtl/ecp_ndiv.sv */
// Pipelined restoring divider: (t * 2^28) / c with a per-word divisor, 42 quotient bits.
// Depends on ecp_pkg.
module ecp_ndiv
	import ecp_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [QuoW-1:0]  num,
	input  logic [CoefW-1:0] den,
	output logic [QuoW-1:0]  quo
);

	localparam int LoW = QuoW - FracW;

	logic [CoefW-1:0] rem_s [0:QuoW];
	logic [CoefW-1:0] den_s [0:QuoW];
	logic [LoW-1:0]   lo_s [0:QuoW];
	logic [QuoW-1:0]  quo_s [0:QuoW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {2'd0, num[QuoW-1:LoW]};
			den_s[0] <= den;
			lo_s[0] <= num[LoW-1:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < QuoW; j++) begin : g_step
		logic [CoefW:0] trial;
		logic           fits;

		assign trial = {rem_s[j], lo_s[j][LoW-1]};
		assign fits = (trial >= {1'b0, den_s[j]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fits ? CoefW'(trial - {1'b0, den_s[j]}) : trial[CoefW-1:0];
				den_s[j+1] <= den_s[j];
				lo_s[j+1] <= {lo_s[j][LoW-2:0], 1'b0};
				quo_s[j+1] <= {quo_s[j][QuoW-2:0], fits};
			end
		end
	end

	assign quo = quo_s[QuoW];

endmodule

/* rtl/eckert3_projection.sv */
// Eckert III projection, forward and inverse, with its configuration registers.
// Depends on ecp_pkg, ecp_wdiv, ecp_coef and ecp_ndiv.
//
// Usage:
//   Input words (cmd, first_coord, second_coord) are taken when item_valid is
//   high and item_stall is low; cmd 0 maps latitude/longitude to easting and
//   northing, cmd 1 maps back. Each input word gives exactly one result word
//   (first_result, second_result, saturated), offered with result_valid and
//   taken when result_stall is low.
//   Both directions take the same path, through two 42-stage divide pipelines
//   with the 29-stage root between them. One word enters per cycle while
//   item_stall is low, and results leave in input order.
//   When a result waits with result_stall high, the whole pipeline holds and
//   item_stall is raised; nothing is lost or repeated.
//   Reset clears all valid bits and loads the register defaults. The user must
//   write registers over the APB port (8-byte spacing) only while the pipeline
//   is empty; the block itself does not enforce this. pready is always high.
module eckert3_projection
	import ecp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     cmd,
	input  logic signed [CoordW-1:0] first_coord,
	input  logic signed [CoordW-1:0] second_coord,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [CoordW-1:0] first_result,
	output logic signed [CoordW-1:0] second_result,
	output logic                     saturated,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [4:0]               paddr,
	input  logic [63:0]              pwdata,
	output logic [63:0]              prdata,
	output logic                     pready
);

	logic [31:0]        axis_q;
	logic [30:0]        lon0_q;
	logic [CoordW-1:0]  fe_q;
	logic [CoordW-1:0]  fn_q;
	logic [63:0]        dena_q;
	logic [63:0]        denb_q;
	reg_idx_t           widx;
	logic               wr_en;

	logic               adv;
	logic [TotalLat-1:0] vld_s;

	logic [CoordW-1:0]  off1_in;
	logic [CoordW-1:0]  off2_in;
	logic               cmd_s1;
	logic [DiffW-1:0]   x1_s1;
	logic [DiffW-1:0]   x2_s1;
	front_t             f_s2;
	front_t             fd_s [0:DivLat-1];
	quo_t               qa;
	quo_t               qb;
	front_t             fq;
	mid_t               mid_in;
	mid_t               mid_s3;
	logic [CoefW-1:0]   lc_s3;
	mid_t               md_s [0:CoefLat-1];
	logic [CoefW-1:0]   coef;
	back_t              bd_s [0:DivLat-1];
	back_t              bk;
	logic [QuoW-1:0]    lon;

	logic [60:0]        kprod;
	mid_t               mid_s4;
	logic [QuoW-1:0]    lon_s4;
	logic [32:0]        kc_s4;
	logic [52:0]        nlo_s4;
	logic [52:0]        nhi_s4;
	logic [74:0]        nsum;
	mid_t               mid_s5;
	logic [QuoW-1:0]    lon_s5;
	logic [53:0]        elo_s5;
	logic [53:0]        ehi_s5;
	logic [45:0]        nmag_s5;
	logic [75:0]        esum;
	mid_t               mid_s6;
	logic [QuoW-1:0]    lon_s6;
	logic [45:0]        emag_s6;
	logic [45:0]        nmag_s6;

	logic [SumW-1:0]    mag1;
	logic [SumW-1:0]    mag2;
	logic [SumW-1:0]    off1;
	logic [SumW-1:0]    off2;
	logic signed [SumW-1:0] sum1;
	logic signed [SumW-1:0] sum2;
	logic               big1;
	logic               big2;
	logic               hi1;
	logic               lo1;
	logic               hi2;
	logic               lo2;
	logic               zero_axis;
	logic [CoordW-1:0]  first_result_s7;
	logic [CoordW-1:0]  second_result_s7;
	logic               saturated_s7;

	// Configuration registers
	assign widx = reg_idx_t'(paddr[4:3]);
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AxisReset;
			lon0_q <= '0;
			fe_q <= '0;
			fn_q <= '0;
		end else if (wr_en) begin
			unique case (widx)
				RegAxis: axis_q <= pwdata[31:0];
				RegLon0: lon0_q <= pwdata[30:0];
				RegFe:   fe_q <= pwdata[CoordW-1:0];
				RegFn:   fn_q <= pwdata[CoordW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			RegAxis: prdata = {32'd0, axis_q};
			RegLon0: prdata = {{33{lon0_q[30]}}, lon0_q};
			RegFe:   prdata = {{24{fe_q[CoordW-1]}}, fe_q};
			RegFn:   prdata = {{24{fn_q[CoordW-1]}}, fn_q};
		endcase
	end

	always_ff @(posedge clk) begin
		dena_q <= {32'd0, axis_q} * {32'd0, CyQ};
		denb_q <= {32'd0, axis_q} * {33'd0, CxQ};
	end

	// Pipeline control
	assign adv = ~(result_valid & result_stall);
	assign item_stall = ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[TotalLat-2:0], item_valid};
		end
	end

	assign result_valid = vld_s[TotalLat-1];

	// Offsets and magnitudes
	assign off1_in = cmd ? fe_q : '0;
	assign off2_in = cmd ? fn_q : {{(CoordW-31){lon0_q[30]}}, lon0_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
			x1_s1 <= {first_coord[CoordW-1], first_coord} - {off1_in[CoordW-1], off1_in};
			x2_s1 <= {second_coord[CoordW-1], second_coord} - {off2_in[CoordW-1], off2_in};
			f_s2.cmd <= cmd_s1;
			f_s2.n1 <= x1_s1[DiffW-1];
			f_s2.n2 <= x2_s1[DiffW-1];
			f_s2.m1 <= x1_s1[DiffW-1] ? DiffW'(0) - x1_s1 : x1_s1;
			f_s2.m2 <= x2_s1[DiffW-1] ? DiffW'(0) - x2_s1 : x2_s1;
		end
	end

	// Latitude and scaled easting divides
	ecp_wdiv u_div_lat (
		.clk (clk),
		.en  (adv),
		.num (f_s2.m2),
		.den (dena_q),
		.res (qa)
	);

	ecp_wdiv u_div_east (
		.clk (clk),
		.en  (adv),
		.num (f_s2.m1),
		.den (denb_q),
		.res (qb)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s[0] <= f_s2;
			for (int i = 1; i < DivLat; i++) begin
				fd_s[i] <= fd_s[i-1];
			end
		end
	end

	assign fq = fd_s[DivLat-1];

	always_comb begin
		mid_in.cmd = fq.cmd;
		mid_in.n1 = fq.n1;
		mid_in.n2 = fq.n2;
		if (fq.cmd) begin
			mid_in.ova = qa.ovf;
			mid_in.ovb = qb.ovf;
			mid_in.a = qa.q;
			mid_in.b = qb.q;
		end else begin
			mid_in.ova = 1'b0;
			mid_in.ovb = 1'b0;
			mid_in.a = {1'b0, fq.m1};
			mid_in.b = {1'b0, fq.m2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s3 <= mid_in;
			lc_s3 <= (mid_in.ova || mid_in.a > {12'd0, LatCap}) ? LatCap
				: mid_in.a[CoefW-1:0];
		end
	end

	// Scale term
	ecp_coef u_coef (
		.clk  (clk),
		.en   (adv),
		.lat  (lc_s3),
		.coef (coef)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			md_s[0] <= mid_s3;
			for (int i = 1; i < CoefLat; i++) begin
				md_s[i] <= md_s[i-1];
			end
		end
	end

	// Longitude divide
	ecp_ndiv u_div_lon (
		.clk (clk),
		.en  (adv),
		.num (md_s[CoefLat-1].b),
		.den (coef),
		.quo (lon)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			bd_s[0] <= {md_s[CoefLat-1], coef};
			for (int i = 1; i < DivLat; i++) begin
				bd_s[i] <= bd_s[i-1];
			end
		end
	end

	assign bk = bd_s[DivLat-1];

	// Forward scaling products
	assign kprod = {30'd0, denb_q[62:32]} * {31'd0, bk.c};
	assign nsum = {22'd0, nlo_s4} + {1'b0, nhi_s4, 21'd0};
	assign esum = {22'd0, elo_s5} + {1'b0, ehi_s5, 21'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s4 <= bk.mid;
			lon_s4 <= lon;
			kc_s4 <= kprod[60:28];
			nlo_s4 <= {21'd0, dena_q[63:32]} * {32'd0, bk.mid.a[20:0]};
			nhi_s4 <= {21'd0, dena_q[63:32]} * {32'd0, bk.mid.a[41:21]};

			mid_s5 <= mid_s4;
			lon_s5 <= lon_s4;
			elo_s5 <= {21'd0, kc_s4} * {33'd0, mid_s4.b[20:0]};
			ehi_s5 <= {21'd0, kc_s4} * {33'd0, mid_s4.b[41:21]};
			nmag_s5 <= nsum[73:28];

			mid_s6 <= mid_s5;
			lon_s6 <= lon_s5;
			emag_s6 <= esum[73:28];
			nmag_s6 <= nmag_s5;
		end
	end

	// Offsets, sign and clamp
	assign mag1 = mid_s6.cmd ? {6'd0, mid_s6.a} : {2'd0, emag_s6};
	assign mag2 = mid_s6.cmd ? {6'd0, lon_s6} : {2'd0, nmag_s6};
	assign off1 = mid_s6.cmd ? '0 : {{(SumW-CoordW){fe_q[CoordW-1]}}, fe_q};
	assign off2 = mid_s6.cmd ? {{(SumW-31){lon0_q[30]}}, lon0_q}
		: {{(SumW-CoordW){fn_q[CoordW-1]}}, fn_q};
	assign sum1 = mid_s6.n2 ? $signed(off1 - mag1) : $signed(off1 + mag1);
	assign sum2 = mid_s6.n1 ? $signed(off2 - mag2) : $signed(off2 + mag2);
	assign big1 = mid_s6.cmd & mid_s6.ova;
	assign big2 = mid_s6.cmd & mid_s6.ovb;
	assign hi1 = big1 ? ~mid_s6.n2 : (sum1 > Max40);
	assign lo1 = big1 ? mid_s6.n2 : (sum1 < Min40);
	assign hi2 = big2 ? ~mid_s6.n1 : (sum2 > Max40);
	assign lo2 = big2 ? mid_s6.n1 : (sum2 < Min40);
	assign zero_axis = mid_s6.cmd & (axis_q == '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_axis) begin
				first_result_s7 <= '0;
				second_result_s7 <= '0;
				saturated_s7 <= 1'b1;
			end else begin
				first_result_s7 <= hi1 ? Max40[CoordW-1:0]
					: lo1 ? Min40[CoordW-1:0] : sum1[CoordW-1:0];
				second_result_s7 <= hi2 ? Max40[CoordW-1:0]
					: lo2 ? Min40[CoordW-1:0] : sum2[CoordW-1:0];
				saturated_s7 <= hi1 | lo1 | hi2 | lo2;
			end
		end
	end

	assign first_result = first_result_s7;
	assign second_result = second_result_s7;
	assign saturated = saturated_s7;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated && (first_result != '0 || second_result != '0)
		|-> first_result == Max40[CoordW-1:0] || first_result == Min40[CoordW-1:0]
			|| second_result == Max40[CoordW-1:0] || second_result == Min40[CoordW-1:0])
		else $error("saturated result word not at a field limit");

	a_lat_capped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QIdx] |-> lc_s3 <= LatCap)
		else $error("latitude into scale term above cap");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[CoefIdx] |-> coef >= One28 && coef <= LatCap)
		else $error("scale term out of range");

endmodule

/* bench/eckert3_checker.sv */
// Checker for the Eckert III projection block: snoops the register port, predicts each result.
// Compares result words field by field in order. Depends on ecp_pkg.
`timescale 1ns / 1ps

module eckert3_checker
	import ecp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_stall,
	input  logic                     cmd,
	input  logic signed [CoordW-1:0] first_coord,
	input  logic signed [CoordW-1:0] second_coord,
	input  logic                     result_valid,
	input  logic                     result_stall,
	input  logic signed [CoordW-1:0] first_result,
	input  logic signed [CoordW-1:0] second_result,
	input  logic                     saturated,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [4:0]               paddr,
	input  logic [63:0]              pwdata,
	input  logic                     pready,
	output int                       errors,
	output int                       pending
);

	localparam logic [63:0] Cap62 = 64'h4000_0000_0000_0000;
	localparam longint Hi40 = 64'sd549755813887;
	localparam longint Lo40 = -64'sd549755813888;

	typedef struct packed {
		logic [CoordW-1:0] r1;
		logic [CoordW-1:0] r2;
		logic              sat;
	} proj_word_t;

	logic [31:0]   axis;
	longint        lon0;
	longint        fe;
	longint        fn;
	proj_word_t    projected_q[$];

	function automatic logic [63:0] magn(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic [63:0] mul_shift(logic [63:0] x, logic [63:0] y, int sh);
		logic [127:0] p;
		logic [127:0] q;
		p = {64'd0, x} * {64'd0, y};
		if ((p[127:64] >> sh) != 0)
			return Cap62;
		q = p >> sh;
		return q[63:0] > Cap62 ? Cap62 : q[63:0];
	endfunction

	function automatic logic [63:0] div_cap(logic [127:0] num, logic [63:0] d);
		logic [127:0] q;
		if (num[127:64] >= d)
			return Cap62;
		q = num / {64'd0, d};
		return q[63:0] > Cap62 ? Cap62 : q[63:0];
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] lat_coef(logic [63:0] latm);
		logic [63:0] lc;
		logic [63:0] sq;
		logic [63:0] p;
		logic [63:0] s;
		lc = latm > (64'd1 << 29) ? (64'd1 << 29) : latm;
		sq = (lc * lc) >> 28;
		p = (sq * 64'(CbQ)) >> 32;
		s = p >= 64'(One28) ? 64'd0 : 64'(One28) - p;
		return 64'(One28) + int_root(s << 28);
	endfunction

	function automatic longint clip40(longint v, inout logic sat);
		if (v > Hi40) begin
			sat = 1'b1;
			return Hi40;
		end
		if (v < Lo40) begin
			sat = 1'b1;
			return Lo40;
		end
		return v;
	endfunction

	function automatic longint with_sign(logic [63:0] m, logic neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic proj_word_t project(logic dir, longint u, longint v);
		proj_word_t w;
		logic       sat;
		longint     r1;
		longint     r2;
		longint     dl;
		longint     dx;
		longint     dy;
		logic [63:0] c;
		logic [63:0] k;
		logic [63:0] e;
		logic [63:0] n;
		logic [63:0] lat;
		logic [63:0] t;
		logic [63:0] lon;
		sat = 1'b0;
		if (dir == 1'b0) begin
			dl = v - lon0;
			c = lat_coef(magn(u));
			k = mul_shift(mul_shift(64'(axis), 64'(CxQ), 32), c, 28);
			e = mul_shift(k, magn(dl), 28);
			n = mul_shift(mul_shift(64'(axis), 64'(CyQ), 32), magn(u), 28);
			r1 = clip40(with_sign(e, dl < 0) + fe, sat);
			r2 = clip40(with_sign(n, u < 0) + fn, sat);
		end else if (axis == 0) begin
			r1 = 0;
			r2 = 0;
			sat = 1'b1;
		end else begin
			dx = u - fe;
			dy = v - fn;
			lat = div_cap({64'd0, magn(dy)} << 60, 64'(axis) * 64'(CyQ));
			c = lat_coef(lat);
			t = div_cap({64'd0, magn(dx)} << 60, 64'(axis) * 64'(CxQ));
			lon = div_cap({64'd0, t} << 28, c);
			r1 = clip40(with_sign(lat, dy < 0), sat);
			r2 = clip40(with_sign(lon, dx < 0) + lon0, sat);
		end
		w.r1 = r1[39:0];
		w.r2 = r2[39:0];
		w.sat = sat;
		return w;
	endfunction

	assign pending = projected_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		int bad;
		bad = 0;
		if (!arst_n) begin
			axis <= AxisReset;
			lon0 <= 0;
			fe <= 0;
			fn <= 0;
			errors <= 0;
			projected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:3]))
					RegAxis: axis <= pwdata[31:0];
					RegLon0: lon0 <= longint'(signed'(pwdata[30:0]));
					RegFe:   fe <= longint'(signed'(pwdata[39:0]));
					RegFn:   fn <= longint'(signed'(pwdata[39:0]));
				endcase
			end
			if (item_valid && !item_stall)
				projected_q.push_back(project(cmd, longint'(first_coord),
					longint'(second_coord)));
			if (result_valid && !result_stall) begin
				if (projected_q.size() == 0) begin
					$error("result word with nothing expected");
					bad = bad + 1;
				end else begin
					if (first_result !== projected_q[0].r1) begin
						$error("first_result: expected %h, got %h",
							projected_q[0].r1, first_result);
						bad = bad + 1;
					end
					if (second_result !== projected_q[0].r2) begin
						$error("second_result: expected %h, got %h",
							projected_q[0].r2, second_result);
						bad = bad + 1;
					end
					if (saturated !== projected_q[0].sat) begin
						$error("saturated: expected %b, got %b",
							projected_q[0].sat, saturated);
						bad = bad + 1;
					end
					void'(projected_q.pop_front());
				end
			end
			errors <= errors + bad;
		end
	end

endmodule

/* bench/testbench.sv */
// Top of the Eckert III projection bench: clock, reset, stimulus, register writes and verdict.
// Depends on ecp_pkg, eckert3_projection and eckert3_checker.
`timescale 1ns / 1ps

module testbench
	import ecp_pkg::*;
;

	localparam int DrainWait = 140;
	localparam int WatchLimit = 6000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic                     cmd = 1'b0;
	logic signed [CoordW-1:0] first_coord = '0;
	logic signed [CoordW-1:0] second_coord = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [CoordW-1:0] first_result;
	logic signed [CoordW-1:0] second_result;
	logic                     saturated;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [4:0]               paddr = '0;
	logic [63:0]              pwdata = '0;
	logic [63:0]              prdata;
	logic                     pready;
	int                       errors;
	int                       pending;
	int                       idle_cycles = 0;
	bit                       gaps_on = 1'b1;
	bit                       long_hold = 1'b0;

	always #1 clk = ~clk;

	eckert3_projection dut (.*);
	eckert3_checker chk (.*);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 16);
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic logic [39:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [39:0] span(longint lim);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return 40'(longint'(r % 64'(2 * lim + 1)) - lim);
	endfunction

	task automatic send(logic dir, logic [39:0] a, logic [39:0] b);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= dir;
		first_coord <= a;
		second_coord <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_item();
		case ($urandom_range(0, 5))
			0: send(1'b0, span(450000000), span(843314857));
			1: send(1'b0, span(600000000), span(1700000000));
			2: send(1'b1, span(64'sd12000000000), span(64'sd6000000000));
			3: send(1'b1, span(64'sd40000000000), span(64'sd40000000000));
			default: send(1'($urandom), rand40(), rand40());
		endcase
	endtask

	task automatic run_phase(int count);
		for (int i = 0; i < count; i++) begin
			random_item();
			if (i == 60 && $urandom_range(0, 1) == 1) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(1'b0, 40'd0, 40'd0);
		send(1'b0, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF);
		send(1'b0, 40'sh80_0000_0000, 40'sh80_0000_0000);
		send(1'b0, 40'sd421657428, 40'sd843314857);
		send(1'b0, -40'sd421657428, -40'sd843314857);
		send(1'b0, 40'sd536870912, 40'sd100000000);
		send(1'b0, 40'sd420000000, -40'sd100000000);
		send(1'b0, 40'sd1000000000, 40'sd5);
		send(1'b1, 40'd0, 40'd0);
		send(1'b1, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF);
		send(1'b1, 40'sh80_0000_0000, 40'sh80_0000_0000);
		send(1'b1, 40'sd4300000000, 40'sd2900000000);
		send(1'b1, -40'sd4300000000, -40'sd2900000000);
		send(1'b1, 40'sd1, -40'sd1);
		drain();

		reg_write(RegAxis, 64'd0);
		send(1'b1, 40'sd12345, 40'sd6789);
		send(1'b0, 40'sd200000000, 40'sd300000000);
		send(1'b1, 40'd0, 40'd0);
		drain();

		reg_write(RegAxis, 64'hFFFF_FFFF);
		reg_write(RegLon0, 64'sd843314857);
		reg_write(RegFe, 64'sd549755813887);
		reg_write(RegFn, -64'sd549755813888);
		send(1'b0, 40'sd421657428, -40'sd843314857);
		send(1'b1, 40'sd0, 40'sd0);
		send(1'b1, 40'sh7F_FFFF_FFFF, 40'sh80_0000_0000);
		run_phase(200);
		drain();

		reg_write(RegAxis, 64'd1632803072);
		reg_write(RegLon0, -64'sd843314857);
		reg_write(RegFe, -64'sd549755813888);
		reg_write(RegFn, 64'sd549755813887);
		long_hold = 1'b1;
		run_phase(220);
		drain();

		for (int p = 0; p < 3; p++) begin
			reg_write(RegAxis, 64'($urandom));
			reg_write(RegLon0, 64'(signed'(span(843314857))));
			reg_write(RegFe, 64'(signed'(span(64'sd3000000000))));
			reg_write(RegFn, 64'(signed'(rand40())));
			if (p == 1)
				long_hold = 1'b1;
			run_phase(200);
			drain();
		end

		reg_write(RegAxis, 64'd1632803072);
		reg_write(RegLon0, 64'd0);
		reg_write(RegFe, 64'sd50000000);
		reg_write(RegFn, -64'sd50000000);
		run_phase(100);
		gaps_on = 1'b0;
		run_phase(160);
		drain();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ecp_pkg.sv
rtl/ecp_wdiv.sv
rtl/ecp_coef.sv
rtl/ecp_ndiv.sv
rtl/eckert3_projection.sv
bench/eckert3_checker.sv
bench/testbench.sv
